/* rtl/pcnt_pkg.sv */
// Package for the partition counter: count type, field widths and the
// queue status bundle shared by the front end and the table engine.
// Depends on nothing.
package pcnt_pkg;

    // Width of one stored count and of the result field.
    localparam int COUNT_W = 63;

    // Widths of the query fields.
    localparam int TOTAL_W = 8;
    localparam int PARTS_W = 8;

    typedef logic [COUNT_W-1:0] count_t;

    // Largest count; additions saturate here.
    localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

    // Fill status of the query queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* rtl/pcnt_query_if.sv */
// Query channel of the partition counter: valid, ready and the query fields.
// Depends on nothing.
interface pcnt_query_if;
    logic       valid;
    logic       ready;
    logic [7:0] total_amount;
    logic [7:0] max_parts;

    modport source (output valid, output total_amount, output max_parts, input ready);
    modport sink (input valid, input total_amount, input max_parts, output ready);
endinterface

/* rtl/pcnt_result_if.sv */
// Result channel of the partition counter: valid, ready and the count.
// Depends on nothing.
interface pcnt_result_if;
    logic        valid;
    logic        ready;
    logic [62:0] way_count;

    modport source (output valid, output way_count, input ready);
    modport sink (input valid, input way_count, output ready);
endinterface

/* rtl/pcnt_front.sv */
// Front end of the partition counter: accepts queries and clamps the total and
// the part bound. Depends on pcnt_pkg and pcnt_query_if.
module pcnt_front #(
    parameter int MAX_TOTAL = 255,
    parameter int IDX_W     = 8
) (
    pcnt_query_if.sink          query,
    input  pcnt_pkg::q_status_t q_stat,
    output logic                push,
    output logic [2*IDX_W-1:0]  push_data
);

    // Common width for comparing the 8-bit fields with the table size.
    localparam int CMP_W = (IDX_W > pcnt_pkg::TOTAL_W) ? IDX_W : pcnt_pkg::TOTAL_W;

    logic [CMP_W-1:0] total_ext;
    logic [CMP_W-1:0] parts_ext;
    logic [CMP_W-1:0] total_sat;
    logic [CMP_W-1:0] parts_sat;

    // A query is taken whenever the queue has room.
    assign query.ready = !q_stat.full;
    assign push        = query.valid && query.ready;

    // Clamp the total to the table size, then the part bound to the total.
    always_comb
    begin
        total_ext = CMP_W'(query.total_amount);
        parts_ext = CMP_W'(query.max_parts);
        total_sat = (total_ext > CMP_W'(MAX_TOTAL)) ? CMP_W'(MAX_TOTAL) : total_ext;
        parts_sat = (parts_ext > total_sat) ? total_sat : parts_ext;
    end

    assign push_data = {IDX_W'(total_sat), IDX_W'(parts_sat)};

endmodule

/* rtl/pcnt_queue.sv */
// Two-entry queue of clamped queries between the front end and the engine.
// Depends on pcnt_pkg.
module pcnt_queue #(
    parameter int DATA_W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [DATA_W-1:0]   push_data,
    input  logic                pop,
    output logic [DATA_W-1:0]   pop_data,
    output pcnt_pkg::q_status_t q_stat
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        fill_reg;
    logic [1:0]        fill_next;

    assign q_stat.full  = (fill_reg == 2'd2);
    assign q_stat.empty = (fill_reg == 2'd0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/pcnt_engine.sv */
// Table engine of the partition counter: clears the count table, runs the
// part-size passes one entry per cycle and holds the answer in the output
// register. Depends on pcnt_pkg and pcnt_result_if.
module pcnt_engine #(
    parameter int MAX_TOTAL = 255,
    parameter int IDX_W     = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcnt_pkg::q_status_t q_stat,
    input  logic [2*IDX_W-1:0]  pop_data,
    output logic                pop,
    pcnt_result_if.source       result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] n_reg;
    logic [IDX_W-1:0] n_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [IDX_W-1:0] s_reg;
    logic [IDX_W-1:0] s_next;
    logic [IDX_W-1:0] r_reg;
    logic [IDX_W-1:0] r_next;

    // Count table and its registered read ports.
    pcnt_pkg::count_t mem [0:MAX_TOTAL];
    pcnt_pkg::count_t rd_a_reg;
    pcnt_pkg::count_t rd_b_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    pcnt_pkg::count_t wr_data;

    // Update stage: addresses read last cycle and the entry to write back.
    logic             upd_valid_reg;
    logic             upd_valid_next;
    logic [IDX_W-1:0] upd_addr_reg;
    logic [IDX_W-1:0] ra_addr_reg;
    logic [IDX_W-1:0] rb_addr_reg;

    // Last write, for bypass when a read and a write share an edge.
    logic             byp_valid_reg;
    logic [IDX_W-1:0] byp_addr_reg;
    pcnt_pkg::count_t byp_data_reg;

    pcnt_pkg::count_t a_val;
    pcnt_pkg::count_t b_val;
    logic [pcnt_pkg::COUNT_W:0] sum_wide;
    pcnt_pkg::count_t sum_sat;

    logic             out_valid_reg;
    logic             out_load;
    pcnt_pkg::count_t way_count_reg;

    // Bypassed read data and saturating add.
    always_comb
    begin
        a_val    = (byp_valid_reg && byp_addr_reg == ra_addr_reg) ? byp_data_reg : rd_a_reg;
        b_val    = (byp_valid_reg && byp_addr_reg == rb_addr_reg) ? byp_data_reg : rd_b_reg;
        sum_wide = {1'b0, a_val} + {1'b0, b_val};
        sum_sat  = sum_wide[pcnt_pkg::COUNT_W] ? pcnt_pkg::COUNT_MAX
                                               : sum_wide[pcnt_pkg::COUNT_W-1:0];
    end

    // Write port: clearing sweep or the update stage, never both.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = upd_addr_reg;
        wr_data = sum_sat;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = r_reg;
            wr_data = (r_reg == '0) ? pcnt_pkg::count_t'(1) : '0;
        end
        else if (upd_valid_reg)
        begin
            wr_en = 1'b1;
        end
    end

    // Sequencer over clearing, part-size passes and the final fetch.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        r_next         = r_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr_a      = r_reg;
        rd_addr_b      = r_reg - s_reg;
        upd_valid_next = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    n_next     = pop_data[2*IDX_W-1:IDX_W];
                    k_next     = pop_data[IDX_W-1:0];
                    r_next     = '0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (r_reg == n_reg)
                begin
                    if (k_reg == '0)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        s_next     = IDX_W'(1);
                        r_next     = IDX_W'(1);
                        state_next = ST_RUN;
                    end
                end
                else
                begin
                    r_next = r_reg + IDX_W'(1);
                end
            end
            ST_RUN:
            begin
                rd_en          = 1'b1;
                upd_valid_next = 1'b1;
                if (r_reg == n_reg)
                begin
                    if (s_reg == k_reg)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        s_next = s_reg + IDX_W'(1);
                        r_next = s_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    r_next = r_reg + IDX_W'(1);
                end
            end
            ST_FETCH:
            begin
                rd_addr_a = n_reg;
                rd_addr_b = n_reg;
                if (!out_valid_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            k_reg         <= '0;
            s_reg         <= '0;
            r_reg         <= '0;
            upd_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            s_reg         <= s_next;
            r_reg         <= r_next;
            upd_valid_reg <= upd_valid_next;
            byp_valid_reg <= wr_en;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Table memory with registered reads; addresses and data need no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg    <= mem[rd_addr_a];
            rd_b_reg    <= mem[rd_addr_b];
            ra_addr_reg <= rd_addr_a;
            rb_addr_reg <= rd_addr_b;
        end
        upd_addr_reg <= r_reg;
        byp_addr_reg <= wr_addr;
        byp_data_reg <= wr_data;
        if (out_load)
        begin
            way_count_reg <= a_val;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.way_count = way_count_reg;

    // The answer is only loaded into an empty output register.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !out_valid_reg)
        else $error("result loaded while output register is full");

    // Each pass stays between its part size and the total.
    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (s_reg <= r_reg && r_reg <= n_reg && s_reg <= k_reg))
        else $error("pass indices out of range");

    // No write reaches past the entry of the current total.
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr <= n_reg))
        else $error("table write beyond the total");

    // A query is only taken from a non-empty queue.
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // The update stage is busy only right after a pass read.
    a_upd_follow: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid_reg |-> $past(state_reg) == ST_RUN)
        else $error("update stage active without a preceding read");

endmodule

/* rtl/partition_count_at_most_k_parts.sv */
// Partition counter: counts the ways to split a total into at most k parts.
// Channels: query (sink) carries total_amount and max_parts; result (source)
// carries the 63-bit way_count, one result per query, in query order.
// Both use valid/ready; a request moves on an edge where both are high.
// The front end clamps the total to MAX_TOTAL and the part bound to the total
// and places the request in a two-entry queue, so queries are taken while the
// engine is busy. The engine takes a query in idle, clears table entries 0..n,
// then runs one table entry per cycle through a registered-read memory with
// two read ports and one write port, for each part size s = 1..k over entries
// s..n. It then fetches entry n and loads the output register. The pass loop
// over the single table memory sets the rate.
// A held result waits in the output register while the receiver stalls; the
// engine finishes its next query and waits at the fetch until it is free.
// Reset (rst_n, asynchronous, active low) empties the queue and the output
// register; the table needs no clearing since every query clears it.
module partition_count_at_most_k_parts #(
    parameter int MAX_TOTAL = 255
) (
    input  logic          clk,
    input  logic          rst_n,
    pcnt_query_if.sink    query,
    pcnt_result_if.source result
);

    localparam int IDX_W = $clog2(MAX_TOTAL + 1);

    pcnt_pkg::q_status_t q_stat;
    logic                push;
    logic [2*IDX_W-1:0]  push_data;
    logic                pop;
    logic [2*IDX_W-1:0]  pop_data;

    // Accept and clamp queries.
    pcnt_front #(
        .MAX_TOTAL (MAX_TOTAL),
        .IDX_W     (IDX_W)
    ) u_front (
        .query     (query),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // Queue between the front end and the engine.
    pcnt_queue #(
        .DATA_W (2 * IDX_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // Table passes and the output register.
    pcnt_engine #(
        .MAX_TOTAL (MAX_TOTAL),
        .IDX_W     (IDX_W)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .result   (result)
    );

endmodule

/* dv/partition_count_at_most_k_parts_tb.sv */
// Testbench for the partition counter: drives queries, predicts each count and
// checks results in order through a small scoreboard class.
// Depends on pcnt_pkg, pcnt_query_if, pcnt_result_if and the top-level RTL.
module partition_count_at_most_k_parts_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TOTAL = 255;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 150000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS = 10;

    // One expected count together with the request that caused it.
    typedef struct {
        logic [pcnt_pkg::TOTAL_W-1:0] total;
        logic [pcnt_pkg::PARTS_W-1:0] parts;
        pcnt_pkg::count_t             count;
    } partition_expect_t;

    // Keeps the predicted counts in request order and compares results with them.
    class partition_scoreboard;
        partition_expect_t pending_counts[$];
        int                error_count;

        function new();
            error_count = 0;
        endfunction

        // Table-based count of partitions of total into at most parts parts.
        function pcnt_pkg::count_t count_partitions(int unsigned total,
                                                    int unsigned parts);
            pcnt_pkg::count_t           ways [MAX_TOTAL+1];
            logic [pcnt_pkg::COUNT_W:0] wide_sum;
            int unsigned                n;
            int unsigned                k;
            n = (total > MAX_TOTAL) ? MAX_TOTAL : total;
            k = (parts > n) ? n : parts;
            foreach (ways[i])
                ways[i] = '0;
            ways[0] = pcnt_pkg::count_t'(1);
            for (int unsigned s = 1; s <= k; s++)
            begin
                for (int unsigned r = s; r <= n; r++)
                begin
                    wide_sum = {1'b0, ways[r]} + {1'b0, ways[r-s]};
                    ways[r] = wide_sum[pcnt_pkg::COUNT_W] ? pcnt_pkg::COUNT_MAX
                                                          : wide_sum[pcnt_pkg::COUNT_W-1:0];
                end
            end
            return ways[n];
        endfunction

        // An accepted request: work out its count and queue it.
        function void note_query(logic [pcnt_pkg::TOTAL_W-1:0] total,
                                 logic [pcnt_pkg::PARTS_W-1:0] parts);
            partition_expect_t entry;
            entry.total = total;
            entry.parts = parts;
            entry.count = count_partitions(total, parts);
            pending_counts.push_back(entry);
        endfunction

        // An accepted result: compare with the oldest expectation.
        function void check_count(pcnt_pkg::count_t got);
            partition_expect_t entry;
            if (pending_counts.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: way_count %0d with no request pending", got);
            end
            else
            begin
                entry = pending_counts.pop_front();
                if (entry.count !== got)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("way_count mismatch: total %0d parts %0d expected %0d got %0d",
                                 entry.total, entry.parts, entry.count, got);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pcnt_query_if  query_ch();
    pcnt_result_if result_ch();

    partition_count_at_most_k_parts #(
        .MAX_TOTAL(MAX_TOTAL)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    partition_scoreboard sb = new();

    int send_idle_pct = 10;
    int recv_idle_pct = 79;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    always #2 clk = ~clk;

    // Watch both channels; feed the scoreboard and guard against a hang.
    always @(posedge clk)
    begin
        if (query_ch.valid === 1'b1 && query_ch.ready === 1'b1)
            sb.note_query(query_ch.total_amount, query_ch.max_parts);
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            sb.check_count(result_ch.way_count);
        if ((query_ch.valid === 1'b1 && query_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", quiet_cycles);
            $display("partition_count_at_most_k_parts_tb: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one request, with random idle cycles first, and wait until it is taken.
    task automatic send_query(input logic [pcnt_pkg::TOTAL_W-1:0] total,
                              input logic [pcnt_pkg::PARTS_W-1:0] parts);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
        end
        query_ch.valid        <= 1'b1;
        query_ch.total_amount <= total;
        query_ch.max_parts    <= parts;
        @(posedge clk);
        while (query_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Mostly small totals keep the run short; a few span the full field range.
    task automatic send_random_queries(input int count);
        logic [pcnt_pkg::TOTAL_W-1:0] total;
        logic [pcnt_pkg::PARTS_W-1:0] parts;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                total = pcnt_pkg::TOTAL_W'($urandom_range(0, 255));
                parts = pcnt_pkg::PARTS_W'($urandom_range(0, 255));
            end
            else
            begin
                total = pcnt_pkg::TOTAL_W'($urandom_range(0, 31));
                if ($urandom_range(0, 1) == 0)
                    parts = pcnt_pkg::PARTS_W'($urandom_range(0, int'(total) + 2));
                else
                    parts = pcnt_pkg::PARTS_W'($urandom_range(0, 255));
            end
            send_query(total, parts);
        end
    endtask

    // Main sequence: reset, directed cases, three idling phases, then drain.
    initial
    begin
        int leftover;
        rst_n                 <= 1'b0;
        query_ch.valid        <= 1'b0;
        query_ch.total_amount <= '0;
        query_ch.max_parts    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero total with any bound, zero bound, bound above the total, extremes.
        send_query(8'd0, 8'd0);
        send_query(8'd0, 8'd255);
        send_query(8'd1, 8'd0);
        send_query(8'd255, 8'd0);
        send_query(8'd1, 8'd1);
        send_query(8'd2, 8'd1);
        send_query(8'd5, 8'd200);
        send_query(8'd5, 8'd5);
        send_query(8'd5, 8'd3);
        send_query(8'd10, 8'd4);
        send_query(8'd7, 8'd128);
        send_query(8'd255, 8'd1);
        send_query(8'd255, 8'd2);
        send_query(8'd255, 8'd255);
        send_query(8'd200, 8'd255);
        send_query(8'd128, 8'd127);
        send_query(8'd85, 8'd170);

        send_random_queries(25);

        send_idle_pct = 79;
        recv_idle_pct = 10;
        send_random_queries(25);

        // Long result stall while requests keep coming, so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++)
            send_query(pcnt_pkg::TOTAL_W'($urandom_range(0, 6)),
                       pcnt_pkg::PARTS_W'($urandom_range(0, 6)));

        send_random_queries(25);
        query_ch.valid <= 1'b0;

        while (sb.pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        leftover = sb.pending_counts.size();
        if (leftover != 0)
        begin
            sb.error_count += leftover;
            $display("%0d expected results never arrived", leftover);
        end
        if (sb.error_count == 0)
            $display("partition_count_at_most_k_parts_tb: done, clean");
        else
            $display("partition_count_at_most_k_parts_tb: done, errors");
        $finish;
    end

endmodule
